/* src/mavg_pkg.sv */
package mavg_pkg;

    localparam int AVG_W      = 10;
    localparam int LIMIT_W    = 10;
    localparam int WIN_REG_W  = 8;
    localparam int ALARM_W    = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [ALARM_W-1:0]   ALARM_ON    = 14'd10000;
    localparam logic [ALARM_W-1:0]   ALARM_OFF   = 14'd0;
    localparam logic [WIN_REG_W-1:0] WINDOW_RST  = 8'd10;
    localparam logic [LIMIT_W-1:0]   LOW_RST     = 10'd40;
    localparam logic [LIMIT_W-1:0]   HIGH_RST    = 10'd231;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW = 2'd0,
        REG_LOW    = 2'd1,
        REG_HIGH   = 2'd2
    } cfg_reg_t;

endpackage

/* src/mavg_if.sv */
interface mavg_in_if #(parameter int SAMPLE_BITS = 10);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mavg_out_if;
    import mavg_pkg::*;
    logic               valid;
    logic               ready;
    logic [AVG_W-1:0]   average;
    logic               in_range;
    logic [AVG_W-1:0]   servo_compare;
    logic [ALARM_W-1:0] alarm_compare;

    modport source (output valid, output average, output in_range, output servo_compare,
                    output alarm_compare, input ready);
    modport sink   (input valid, input average, input in_range, input servo_compare,
                    input alarm_compare, output ready);
endinterface

interface mavg_cfg_if;
    import mavg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/mavg_store.sv */
module mavg_store #(
    parameter int DEPTH  = 128,
    parameter int DATA_W = 10
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/mavg_div.sv */
module mavg_div #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient,
    output logic             done
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* src/moving_average_servo_gate_top.sv */
// Channel  | Dir | Payload
// samples  | in  | sample
// results  | out | average, in_range, servo_compare, alarm_compare
// cfg      | in  | index, data (0 window_size, 1 pulse_low_limit, 2 pulse_high_limit)
//
// One item is processed at a time: the store read issues on the accept edge, S_READ updates
// the running sum, writes the sample back and starts a bit-serial divider that produces one
// quotient bit per cycle over the sum width, then S_DIV loads the result register once the
// divider is done and the result register is free, and the block returns to S_IDLE.
// Reset clears control state only; the sample store is never cleared, entries are written
// in the current fill phase before they are read.
// A result waiting on results.ready does not block the next item being accepted; the
// divider output is held until the result register is free.
module moving_average_servo_gate_top #(
    parameter int MAX_WINDOW  = 128,
    parameter int SAMPLE_BITS = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    mavg_in_if.sink       samples,
    mavg_out_if.source    results,
    mavg_cfg_if.sink      cfg
);
    import mavg_pkg::*;

    localparam int POS_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + POS_W + 1;
    localparam int CMP_W = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DIV  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [WIN_REG_W-1:0]   window_reg, window_next;
    logic [LIMIT_W-1:0]     low_reg, low_next;
    logic [LIMIT_W-1:0]     high_reg, high_next;
    logic [POS_W-1:0]       wpos_reg, wpos_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [AVG_W-1:0]       held_reg, held_next;
    logic                   out_valid_reg, out_valid_next;
    logic [AVG_W-1:0]       avg_reg, avg_next;
    logic                   ok_reg, ok_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [POS_W-1:0]       pos_reg;

    logic [CNT_W-1:0]       win;
    logic [POS_W-1:0]       pos_cur;
    logic [CNT_W-1:0]       pos_inc;
    logic                   in_acc;
    logic                   cfg_acc;
    logic                   slot_free;
    logic                   load_out;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   div_start;
    logic [SUM_W-1:0]       quotient;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] avg_full;
    logic                   ok;

    always_comb
    begin
        if (window_reg == '0)
        begin
            win = CNT_W'(1);
        end
        else if (32'(window_reg) > MAX_WINDOW)
        begin
            win = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win = CNT_W'(window_reg);
        end
    end

    assign pos_cur   = (CNT_W'(wpos_reg) >= win) ? '0 : wpos_reg;
    assign pos_inc   = CNT_W'(pos_reg) + CNT_W'(1);
    assign in_acc    = samples.valid && samples.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign slot_free = !out_valid_reg || results.ready;
    assign load_out  = (state_reg == S_DIV) && div_done && slot_free;
    assign div_start = (state_reg == S_READ);

    assign avg_full = quotient[SAMPLE_BITS-1:0];
    assign ok = (CMP_W'(avg_full) >= CMP_W'(low_reg)) && (CMP_W'(avg_full) <= CMP_W'(high_reg));

    mavg_store #(
        .DEPTH  (MAX_WINDOW),
        .DATA_W (SAMPLE_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (state_reg == S_READ),
        .wr_addr (pos_reg),
        .wr_data (sample_reg),
        .rd_en   (in_acc),
        .rd_addr (pos_cur),
        .rd_data (rd_data)
    );

    mavg_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (fill_next),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        wpos_next      = wpos_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        avg_next       = avg_reg;
        ok_next        = ok_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_acc)
        begin
            unique case (cfg.index)
                REG_WINDOW:
                begin
                    window_next = cfg.data[WIN_REG_W-1:0];
                    wpos_next   = '0;
                    fill_next   = '0;
                    sum_next    = '0;
                end
                REG_LOW:  low_next  = cfg.data[LIMIT_W-1:0];
                REG_HIGH: high_next = cfg.data[LIMIT_W-1:0];
                default:  ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (fill_reg < win)
                begin
                    sum_next  = sum_reg + SUM_W'(sample_reg);
                    fill_next = fill_reg + CNT_W'(1);
                end
                else
                begin
                    sum_next = sum_reg - SUM_W'(rd_data) + SUM_W'(sample_reg);
                end
                wpos_next  = (pos_inc >= win) ? '0 : POS_W'(pos_inc);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    avg_next       = AVG_W'(avg_full);
                    ok_next        = ok;
                    if (ok)
                    begin
                        held_next = AVG_W'(avg_full);
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WINDOW_RST;
            low_reg       <= LOW_RST;
            high_reg      <= HIGH_RST;
            wpos_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            wpos_reg      <= wpos_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg <= avg_next;
        ok_reg  <= ok_next;
        if (in_acc)
        begin
            sample_reg <= samples.sample;
            pos_reg    <= pos_cur;
        end
    end

    assign samples.ready         = (state_reg == S_IDLE);
    assign cfg.ready             = 1'b1;
    assign results.valid         = out_valid_reg;
    assign results.average       = avg_reg;
    assign results.in_range      = ok_reg;
    assign results.servo_compare = held_reg;
    assign results.alarm_compare = ok_reg ? ALARM_OFF : ALARM_ON;

endmodule

/* src/mavg_checker.sv */
module mavg_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [mavg_pkg::AVG_W-1:0]   average,
    input logic                         in_range,
    input logic [mavg_pkg::AVG_W-1:0]   servo_compare,
    input logic [mavg_pkg::ALARM_W-1:0] alarm_compare
);
    import mavg_pkg::*;

    // one item in flight: ready drops straight after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while previous item in flight");

    a_alarm_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((in_range && alarm_compare == ALARM_OFF) ||
                       (!in_range && alarm_compare == ALARM_ON)))
        else $error("alarm compare disagrees with in_range");

    a_servo_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_range) |-> (servo_compare == average))
        else $error("in-range item without servo update");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(average) && $stable(in_range)
                                       && $stable(servo_compare)))
        else $error("stalled result changed");

endmodule

bind moving_average_servo_gate_top mavg_checker u_mavg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .average       (results.average),
    .in_range      (results.in_range),
    .servo_compare (results.servo_compare),
    .alarm_compare (results.alarm_compare)
);
